[rtl/hcb_pkg.sv]
// Shared constants, types and command structs of the Huffman code builder.
package hcb_pkg;

    localparam int MAX_SYMBOLS = 16;
    localparam int NODE_CELLS  = 2 * MAX_SYMBOLS - 1;
    localparam int WEIGHT_W    = 16;
    localparam int NODE_W      = 20;
    localparam int IDX_W       = 5;
    localparam int COUNT_W     = 5;
    localparam int CODE_W      = 15;
    localparam int LEN_W       = 4;
    localparam int SYM_W       = 4;

    // Running pair of the two lightest parentless nodes seen so far in a scan.
    typedef struct packed {
        logic              have_a;
        logic [IDX_W-1:0]  a;
        logic [NODE_W-1:0] wa;
        logic              have_b;
        logic [IDX_W-1:0]  b;
        logic [NODE_W-1:0] wb;
    } pick_t;

    // Broadcast to the node cells.
    typedef struct packed {
        logic              clear;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [NODE_W-1:0] wr_weight;
        logic              mark_en;
        logic [IDX_W-1:0]  mark_p;
        logic [IDX_W-1:0]  mark_q;
    } node_cmd_t;

    // Broadcast to the leaf cells.
    typedef struct packed {
        logic             init_en;
        logic [IDX_W-1:0] init_idx;
        logic             merge_en;
        logic [IDX_W-1:0] p;
        logic [IDX_W-1:0] q;
        logic [IDX_W-1:0] nd;
    } leaf_cmd_t;

endpackage

[rtl/hcb_node_cell.sv]
// One tree node: holds its weight and parent flag, and takes part in the minimum scan.
module hcb_node_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [hcb_pkg::IDX_W-1:0] cell_idx,
    input  hcb_pkg::node_cmd_t        cmd,
    input  hcb_pkg::pick_t            pick_in,
    output hcb_pkg::pick_t            pick_out
);

    logic                       live_reg;
    logic                       has_parent_reg;
    logic [hcb_pkg::NODE_W-1:0] weight_reg;
    hcb_pkg::pick_t             pick_reg;
    hcb_pkg::pick_t             pick_next;

    // Node state: written on load or merge, marked when it gains a parent.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            live_reg       <= 1'b0;
            has_parent_reg <= 1'b0;
        end else begin
            if (cmd.wr_en && cmd.wr_idx == cell_idx) begin
                live_reg       <= 1'b1;
                has_parent_reg <= 1'b0;
            end
            if (cmd.mark_en && (cmd.mark_p == cell_idx || cmd.mark_q == cell_idx)) begin
                has_parent_reg <= 1'b1;
            end
        end
        if (cmd.wr_en && cmd.wr_idx == cell_idx) begin
            weight_reg <= cmd.wr_weight;
        end
    end

    // Fold this node into the running pair; a tie goes to this, the later, node.
    always_comb begin
        pick_next = pick_in;
        if (live_reg && !has_parent_reg) begin
            if (!pick_in.have_a) begin
                pick_next.have_a = 1'b1;
                pick_next.a      = cell_idx;
                pick_next.wa     = weight_reg;
            end else if (weight_reg <= pick_in.wa) begin
                pick_next.have_b = 1'b1;
                pick_next.b      = pick_in.a;
                pick_next.wb     = pick_in.wa;
                pick_next.a      = cell_idx;
                pick_next.wa     = weight_reg;
            end else if (!pick_in.have_b || weight_reg <= pick_in.wb) begin
                pick_next.have_b = 1'b1;
                pick_next.b      = cell_idx;
                pick_next.wb     = weight_reg;
            end
        end
    end

    // The pair moves on to the next cell every cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pick_reg <= '0;
        end else begin
            pick_reg <= pick_next;
        end
    end

    assign pick_out = pick_reg;

endmodule

[rtl/hcb_leaf_cell.sv]
// One symbol: tracks the subtree root above it and grows its code at each merge.
module hcb_leaf_cell (
    input  logic                       aclk,
    input  logic [hcb_pkg::IDX_W-1:0]  cell_idx,
    input  hcb_pkg::leaf_cmd_t         cmd,
    output logic [hcb_pkg::CODE_W-1:0] code_bits,
    output logic [hcb_pkg::LEN_W-1:0]  code_length
);

    logic [hcb_pkg::IDX_W-1:0]  top_reg;
    logic [hcb_pkg::CODE_W-1:0] bits_reg;
    logic [hcb_pkg::LEN_W-1:0]  len_reg;

    // The left child takes a one, the right child a zero, above the bits so far.
    always_ff @(posedge aclk) begin
        if (cmd.init_en && cmd.init_idx == cell_idx) begin
            top_reg  <= cell_idx;
            bits_reg <= '0;
            len_reg  <= '0;
        end else if (cmd.merge_en && top_reg == cmd.p) begin
            top_reg  <= cmd.nd;
            bits_reg <= bits_reg | (hcb_pkg::CODE_W'(1) << len_reg);
            len_reg  <= len_reg + 1'b1;
        end else if (cmd.merge_en && top_reg == cmd.q) begin
            top_reg <= cmd.nd;
            len_reg <= len_reg + 1'b1;
        end
    end

    assign code_bits   = bits_reg;
    assign code_length = len_reg;

endmodule

[rtl/huffman_code_builder.sv]
// Top level of the Huffman code builder: load, merge sequencer and result output.
//
// Weights are taken one per transfer, up to 16; further weights are dropped and flagged.
// The transfer with tlast starts the build. Each merge scans a row of 31 node cells,
// the running pair of lightest nodes moving one cell per cycle, and a set of n symbols
// needs n-1 merges. One result per symbol then follows, one per cycle while m_tready
// is high. Input is refused from the last weight until the final result has been taken.
module huffman_code_builder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] weight
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] symbol, [18:4] code_bits, [22:19] code_length,
                                   // [23] overflow
    output logic        m_tlast
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_OUT
    } state_t;

    state_t                        state_reg;
    logic [hcb_pkg::IDX_W-1:0]     cnt_reg;
    logic [hcb_pkg::IDX_W-1:0]     nd_reg;
    logic [hcb_pkg::COUNT_W-1:0]   count_reg;
    logic                          ovf_reg;
    logic [hcb_pkg::SYM_W-1:0]     out_idx_reg;

    hcb_pkg::node_cmd_t            node_cmd;
    hcb_pkg::leaf_cmd_t            leaf_cmd;
    hcb_pkg::pick_t                pick [hcb_pkg::NODE_CELLS];
    logic [hcb_pkg::CODE_W-1:0]    leaf_bits [hcb_pkg::MAX_SYMBOLS];
    logic [hcb_pkg::LEN_W-1:0]     leaf_len  [hcb_pkg::MAX_SYMBOLS];

    logic                          in_xfer;
    logic                          out_xfer;
    logic                          room;
    logic [hcb_pkg::COUNT_W-1:0]   count_inc;
    logic                          scan_done;
    logic [hcb_pkg::IDX_W-1:0]     last_nd;
    logic                          out_final;
    hcb_pkg::pick_t                result;

    assign in_xfer   = s_tvalid && s_tready;
    assign out_xfer  = m_tvalid && m_tready;
    assign room      = count_reg < hcb_pkg::COUNT_W'(hcb_pkg::MAX_SYMBOLS);
    assign count_inc = count_reg + 1'b1;
    assign scan_done = (state_reg == ST_SCAN) && (cnt_reg == hcb_pkg::IDX_W'(hcb_pkg::NODE_CELLS));
    assign last_nd   = hcb_pkg::IDX_W'({count_reg, 1'b0} - 6'd1);
    assign out_final = hcb_pkg::COUNT_W'(out_idx_reg) == count_reg - 1'b1;
    assign result    = pick[hcb_pkg::NODE_CELLS-1];

    // Commands to the cell rows.
    always_comb begin
        node_cmd           = '0;
        leaf_cmd           = '0;
        node_cmd.clear     = out_xfer && out_final;
        node_cmd.wr_en     = (in_xfer && room) || scan_done;
        node_cmd.wr_idx    = scan_done ? nd_reg : count_inc;
        node_cmd.wr_weight = scan_done ? result.wa + result.wb
                                       : hcb_pkg::NODE_W'(s_tdata);
        node_cmd.mark_en   = scan_done;
        node_cmd.mark_p    = result.a;
        node_cmd.mark_q    = result.b;
        leaf_cmd.init_en   = in_xfer && room;
        leaf_cmd.init_idx  = count_inc;
        leaf_cmd.merge_en  = scan_done;
        leaf_cmd.p         = result.a;
        leaf_cmd.q         = result.b;
        leaf_cmd.nd        = nd_reg;
    end

    // Row of node cells; the first takes an empty pair.
    for (genvar g = 0; g < hcb_pkg::NODE_CELLS; g++) begin : g_node
        hcb_node_cell u_node (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (hcb_pkg::IDX_W'(g + 1)),
            .cmd      (node_cmd),
            .pick_in  ((g == 0) ? hcb_pkg::pick_t'('0) : pick[(g == 0) ? 0 : g - 1]),
            .pick_out (pick[g])
        );
    end

    // Row of leaf cells, one per symbol.
    for (genvar g = 0; g < hcb_pkg::MAX_SYMBOLS; g++) begin : g_leaf
        hcb_leaf_cell u_leaf (
            .aclk        (aclk),
            .cell_idx    (hcb_pkg::IDX_W'(g + 1)),
            .cmd         (leaf_cmd),
            .code_bits   (leaf_bits[g]),
            .code_length (leaf_len[g])
        );
    end

    // Sequencer: load, one scan and merge per new node, then the results.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            nd_reg      <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            out_idx_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (in_xfer) begin
                        if (room) begin
                            count_reg <= count_inc;
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            cnt_reg     <= '0;
                            out_idx_reg <= '0;
                            nd_reg      <= room ? count_inc + 1'b1 : count_inc;
                            if (room && count_reg == '0) begin
                                state_reg <= ST_OUT;
                            end else begin
                                state_reg <= ST_SCAN;
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    if (scan_done) begin
                        cnt_reg <= '0;
                        nd_reg  <= nd_reg + 1'b1;
                        if (nd_reg == last_nd) begin
                            state_reg <= ST_OUT;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_OUT: begin
                    if (out_xfer) begin
                        out_idx_reg <= out_idx_reg + 1'b1;
                        if (out_final) begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tlast  = out_final;
    assign m_tdata  = {ovf_reg, leaf_len[out_idx_reg], leaf_bits[out_idx_reg], out_idx_reg};

endmodule
